>>> rtl/core/ffba_pkg.sv
// shared codes and field widths of the first-fit block allocator
`default_nettype none

package ffba_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned SIZE_W = 16;
    localparam int unsigned HDL_W  = 8;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned LIM_W  = 17;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] status_t;

    localparam op_t OP_ALLOC   = 2'd0;
    localparam op_t OP_FREE    = 2'd1;
    localparam op_t OP_REALLOC = 2'd2;
    localparam op_t OP_CALLOC  = 2'd3;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_NULL   = 2'd1;
    localparam status_t ST_OOM    = 2'd2;
    localparam status_t ST_DOUBLE = 2'd3;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 17'd65536;

endpackage

`default_nettype wire

>>> rtl/core/first_fit_block_allocator_core.sv
// first-fit block allocator: sequencer around one block table memory
//
//  channel   | signals                          | moves
//  ----------+----------------------------------+----------------------------------
//  s_        | s_tvalid s_tready s_tdata s_tuser | one request: operation and args
//  m_        | m_tvalid m_tready m_tdata m_tuser | one answer per request
//  cfg_      | cfg_we cfg_wdata                  | heap_limit write
//
//  one request at a time; a request visits blocks in the first-fit walk, absorbs free
//  successors while freeing, and appends a block when none fits; the walk reads the
//  block table one entry a cycle.
//  reset clears the list, heap top and block count; table entries need no clearing.
//  a finished answer waits in the output register; the next request is taken
//  while it waits, and stalls only when its own answer is ready first.
`default_nettype none

module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24
) (
    input  wire         clk,
    input  wire         rst_n,
    // size[15:0], count[31:16], has_block[32], block_handle[40:33], zero pad
    input  wire  [47:0] s_tdata,
    // operation[1:0]
    input  wire  [ffba_pkg::OP_W-1:0] s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // result_handle[7:0], payload_offset[23:8], granted_size[39:24]
    output logic [39:0] m_tdata,
    // status[1:0]
    output logic [ffba_pkg::ST_W-1:0] m_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         cfg_we,
    input  wire  [ffba_pkg::LIM_W-1:0] cfg_wdata
);
    import ffba_pkg::*;

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int SW  = IW + 1;                      // link width, holds the no-entry mark
    localparam int HTW = $clog2(HEAP_BYTES + 1);
    localparam int NW  = ((HTW > LIM_W) ? HTW : LIM_W) + 1;
    localparam int EW  = HTW + SIZE_W + 1 + SW;
    localparam logic [SW-1:0] NO_ENTRY = SW'(MAX_BLOCKS);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_GINIT = 4'd2;
    localparam logic [3:0] S_GSCAN = 4'd3;
    localparam logic [3:0] S_GAPP  = 4'd4;
    localparam logic [3:0] S_GLINK = 4'd5;
    localparam logic [3:0] S_RECHK = 4'd6;
    localparam logic [3:0] S_RRD   = 4'd7;
    localparam logic [3:0] S_RHEAD = 4'd8;
    localparam logic [3:0] S_RNEXT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              has_reg, has_next;
    logic [HDL_W-1:0]  hdl_reg, hdl_next;
    logic [31:0]       prod_reg, prod_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [SW-1:0]     n_reg, n_next;
    logic [SW-1:0]     first_reg, first_next;
    logic [SW-1:0]     last_reg, last_next;
    logic [HTW-1:0]    top_reg, top_next;
    logic [SW-1:0]     used_reg, used_next;
    logic [LIM_W-1:0]  limit_reg;
    logic [IW-1:0]     link_reg, link_next;
    logic              grow_reg, grow_next;    // realloc that needs a new block
    logic              hfree_reg, hfree_next;  // old block already free
    logic [HTW-1:0]    hs_start_reg, hs_start_next;
    logic [SIZE_W-1:0] hs_size_reg, hs_size_next;
    logic [SW-1:0]     hs_succ_reg, hs_succ_next;
    status_t           res_st_reg, res_st_next;
    logic              res_hv_reg, res_hv_next;
    logic [IW-1:0]     res_h_reg, res_h_next;
    logic [HTW-1:0]    res_start_reg, res_start_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic              mv_reg, mv_next;
    logic [39:0]       md_reg, md_next;
    status_t           mu_reg, mu_next;

    // table memory
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry word: {start, size, free, successor}
    logic [HTW-1:0]    d_start;
    logic [SIZE_W-1:0] d_size;
    logic              d_free;
    logic [SW-1:0]     d_succ;
    assign {d_start, d_size, d_free, d_succ} = ram_rdata;

    logic [IW-1:0]     hidx;
    logic              known;
    logic [NW-1:0]     need, limit;
    logic [SW-1:0]     n_inc;
    logic [17:0]       merged;
    logic [SIZE_W-1:0] merged_sat;

    assign hidx       = IW'(hdl_reg);
    assign known      = has_reg && (32'(hdl_reg) < 32'(used_reg));
    assign need       = NW'(top_reg) + NW'(HEADER_BYTES) + NW'(req_reg);
    assign limit      = (NW'(limit_reg) < NW'(HEAP_BYTES)) ? NW'(limit_reg) : NW'(HEAP_BYTES);
    assign n_inc      = n_reg + SW'(1);
    assign merged     = 18'(hs_size_reg) + 18'(HEADER_BYTES) + 18'(d_size);
    assign merged_sat = (merged > 18'h0FFFF) ? 16'hFFFF : merged[15:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        has_next       = has_reg;
        hdl_next       = hdl_reg;
        prod_next      = prod_reg;
        req_next       = req_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        top_next       = top_reg;
        used_next      = used_reg;
        link_next      = link_reg;
        grow_next      = grow_reg;
        hfree_next     = hfree_reg;
        hs_start_next  = hs_start_reg;
        hs_size_next   = hs_size_reg;
        hs_succ_next   = hs_succ_reg;
        res_st_next    = res_st_reg;
        res_hv_next    = res_hv_reg;
        res_h_next     = res_h_reg;
        res_start_next = res_start_reg;
        res_size_next  = res_size_reg;
        mv_next        = mv_reg;
        md_next        = md_reg;
        mu_next        = mu_reg;
        ram_we         = 1'b0;
        ram_waddr      = hidx;
        ram_wdata      = ram_rdata;
        ram_raddr      = hidx;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    size_next  = s_tdata[15:0];
                    has_next   = s_tdata[32];
                    hdl_next   = s_tdata[40:33];
                    prod_next  = {16'd0, s_tdata[15:0]} * {16'd0, s_tdata[31:16]};
                    grow_next  = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_hv_next = 1'b0;
                res_st_next = ST_OK;
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        req_next   = size_reg;
                        state_next = S_GINIT;
                    end
                    OP_FREE:
                    begin
                        if (!has_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else if (!known)
                        begin
                            res_st_next = ST_DOUBLE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RHEAD;
                        end
                    end
                    OP_REALLOC:
                    begin
                        if (!has_reg || size_reg == '0)
                        begin
                            req_next   = size_reg;
                            state_next = S_GINIT;
                        end
                        else if (!known)
                        begin
                            res_st_next = ST_DOUBLE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RECHK;
                        end
                    end
                    OP_CALLOC:
                    begin
                        req_next = prod_reg[15:0];
                        if (prod_reg == '0)
                        begin
                            res_st_next = ST_NULL;
                            state_next  = S_DONE;
                        end
                        else if (prod_reg[31:16] != '0)
                        begin
                            res_st_next = ST_OOM;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_GINIT;
                        end
                    end
                endcase
            end
            S_RECHK:
            begin
                // old block already large enough: answer it as is
                if (d_size >= size_reg)
                begin
                    res_st_next    = ST_OK;
                    res_hv_next    = 1'b1;
                    res_h_next     = hidx;
                    res_start_next = d_start;
                    res_size_next  = d_size;
                    state_next     = S_DONE;
                end
                else
                begin
                    hfree_next = d_free;
                    grow_next  = 1'b1;
                    req_next   = size_reg;
                    state_next = S_GINIT;
                end
            end
            S_GINIT:
            begin
                ram_raddr = IW'(first_reg);
                n_next    = '0;
                cur_next  = first_reg;
                if (req_reg == '0)
                begin
                    res_st_next = ST_NULL;
                    state_next  = S_DONE;
                end
                else if (used_reg != '0 && first_reg != NO_ENTRY)
                begin
                    state_next = S_GSCAN;
                end
                else
                begin
                    state_next = S_GAPP;
                end
            end
            S_GSCAN:
            begin
                ram_raddr = IW'(d_succ);
                if (d_free && d_size >= req_reg)
                begin
                    // first fit: claim it whole
                    ram_we         = 1'b1;
                    ram_waddr      = IW'(cur_reg);
                    ram_wdata      = {d_start, d_size, 1'b0, d_succ};
                    res_h_next     = IW'(cur_reg);
                    res_start_next = d_start;
                    res_size_next  = d_size;
                    state_next     = (grow_reg && !hfree_reg) ? S_RRD : S_DONE;
                    res_st_next    = ST_OK;
                    res_hv_next    = 1'b1;
                end
                else if (n_inc < used_reg && d_succ != NO_ENTRY)
                begin
                    cur_next = d_succ;
                    n_next   = n_inc;
                end
                else
                begin
                    state_next = S_GAPP;
                end
            end
            S_GAPP:
            begin
                ram_raddr = IW'(last_reg);
                if (used_reg == NO_ENTRY || need > limit)
                begin
                    res_st_next = ST_OOM;
                    state_next  = S_DONE;
                end
                else
                begin
                    // append a block at the heap top
                    ram_we         = 1'b1;
                    ram_waddr      = IW'(used_reg);
                    ram_wdata      = {top_reg, req_reg, 1'b0, NO_ENTRY};
                    used_next      = used_reg + SW'(1);
                    top_next       = HTW'(need);
                    res_h_next     = IW'(used_reg);
                    res_start_next = top_reg;
                    res_size_next  = req_reg;
                    res_st_next    = ST_OK;
                    res_hv_next    = 1'b1;
                    last_next      = used_reg;
                    link_next      = IW'(last_reg);
                    if (first_reg == NO_ENTRY)
                    begin
                        first_next = used_reg;
                        state_next = (grow_reg && !hfree_reg) ? S_RRD : S_DONE;
                    end
                    else if (last_reg != NO_ENTRY)
                    begin
                        state_next = S_GLINK;
                    end
                    else
                    begin
                        state_next = (grow_reg && !hfree_reg) ? S_RRD : S_DONE;
                    end
                end
            end
            S_GLINK:
            begin
                // old tail now points at the new block
                ram_we     = 1'b1;
                ram_waddr  = link_reg;
                ram_wdata  = {d_start, d_size, d_free, SW'(res_h_reg)};
                state_next = (grow_reg && !hfree_reg) ? S_RRD : S_DONE;
            end
            S_RRD:
            begin
                state_next = S_RHEAD;
            end
            S_RHEAD:
            begin
                ram_raddr     = IW'(d_succ);
                hs_start_next = d_start;
                hs_size_next  = d_size;
                hs_succ_next  = d_succ;
                if (op_reg == OP_FREE && d_free)
                begin
                    res_st_next = ST_DOUBLE;
                    state_next  = S_DONE;
                end
                else if (d_succ == NO_ENTRY)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {d_start, d_size, 1'b1, d_succ};
                    state_next = S_DONE;
                    if (op_reg == OP_FREE)
                    begin
                        res_hv_next    = 1'b1;
                        res_h_next     = hidx;
                        res_start_next = d_start;
                        res_size_next  = d_size;
                    end
                end
                else
                begin
                    state_next = S_RNEXT;
                end
            end
            S_RNEXT:
            begin
                ram_raddr = IW'(d_succ);
                if (!d_free)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {hs_start_reg, hs_size_reg, 1'b1, hs_succ_reg};
                    state_next = S_DONE;
                    if (op_reg == OP_FREE)
                    begin
                        res_hv_next    = 1'b1;
                        res_h_next     = hidx;
                        res_start_next = hs_start_reg;
                        res_size_next  = hs_size_reg;
                    end
                end
                else
                begin
                    // absorb the free successor
                    hs_size_next = merged_sat;
                    hs_succ_next = d_succ;
                    if (hs_succ_reg == last_reg)
                    begin
                        last_next = SW'(hidx);
                    end
                    if (d_succ == NO_ENTRY)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {hs_start_reg, merged_sat, 1'b1, d_succ};
                        state_next = S_DONE;
                        if (op_reg == OP_FREE)
                        begin
                            res_hv_next    = 1'b1;
                            res_h_next     = hidx;
                            res_start_next = hs_start_reg;
                            res_size_next  = merged_sat;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    mu_next = res_st_reg;
                    if (res_st_reg == ST_OK && res_hv_reg)
                    begin
                        md_next = {res_size_reg,
                                   16'(NW'(res_start_reg) + NW'(HEADER_BYTES)),
                                   8'(res_h_reg)};
                    end
                    else
                    begin
                        md_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= NO_ENTRY;
            last_reg  <= NO_ENTRY;
            top_reg   <= '0;
            used_reg  <= '0;
            limit_reg <= LIMIT_RESET;
            mv_reg    <= 1'b0;
            grow_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            top_reg   <= top_next;
            used_reg  <= used_next;
            mv_reg    <= mv_next;
            grow_reg  <= grow_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        has_reg       <= has_next;
        hdl_reg       <= hdl_next;
        prod_reg      <= prod_next;
        req_reg       <= req_next;
        cur_reg       <= cur_next;
        n_reg         <= n_next;
        link_reg      <= link_next;
        hfree_reg     <= hfree_next;
        hs_start_reg  <= hs_start_next;
        hs_size_reg   <= hs_size_next;
        hs_succ_reg   <= hs_succ_next;
        res_st_reg    <= res_st_next;
        res_hv_reg    <= res_hv_next;
        res_h_reg     <= res_h_next;
        res_start_reg <= res_start_next;
        res_size_reg  <= res_size_next;
        md_reg        <= md_next;
        mu_reg        <= mu_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/ffba_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/ffba_checker.sv
// port-level checks of the allocator, bound to the top level
`default_nettype none

module ffba_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire [ffba_pkg::ST_W-1:0] m_tuser
);
    import ffba_pkg::*;

    // a failed request carries no handle, offset or size
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("failed request carries nonzero fields");

    // one request in flight: taking one closes the input next cycle
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    // an answer never appears in the cycle right after a request is taken
    a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("answer appeared too early");

    // stalled answer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled answer changed");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench of the first-fit block allocator core
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import ffba_pkg::*;

    localparam int NUM_BLOCKS  = 256;
    localparam int HEAP_SIZE   = 65536;
    localparam int HDR_BYTES   = 24;
    localparam int NONE        = NUM_BLOCKS;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [7:0]  handle;
        logic        has;
        logic [15:0] count;
        logic [15:0] size;
        op_t         op;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  handle;
        logic [15:0] offset;
        logic [15:0] granted;
    } answer_t;

    logic clk;
    logic rst_n;
    logic [47:0] s_tdata;
    op_t s_tuser;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] m_tdata;
    status_t m_tuser;
    logic m_tvalid;
    logic m_tready;
    logic cfg_we;
    logic [LIM_W-1:0] cfg_wdata;

    // shadow of the block table and heap bookkeeping
    int blk_start [NUM_BLOCKS];
    int blk_size [NUM_BLOCKS];
    bit blk_free [NUM_BLOCKS];
    int blk_next [NUM_BLOCKS];
    int head_blk;
    int tail_blk;
    int heap_top;
    int blocks_used;
    int heap_limit;

    request_t pending_reqs[$];
    answer_t expected_answers[$];
    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int cycles;
    int answers_seen;

    first_fit_block_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // first-fit search, else append at the heap top; returns NONE on failure
    function automatic int grant_block(input int sz, output status_t st);
        int cur;
        int idx;
        int need;
        int lim;
        cur = head_blk;
        if (sz == 0)
        begin
            st = ST_NULL;
            return NONE;
        end
        for (int n = 0; n < blocks_used && cur < NONE; n++)
        begin
            if (blk_free[cur] && blk_size[cur] >= sz)
            begin
                blk_free[cur] = 1'b0;
                st = ST_OK;
                return cur;
            end
            cur = blk_next[cur];
        end
        lim = heap_limit < HEAP_SIZE ? heap_limit : HEAP_SIZE;
        need = heap_top + HDR_BYTES + sz;
        if (blocks_used >= NONE || need > lim)
        begin
            st = ST_OOM;
            return NONE;
        end
        idx = blocks_used;
        blocks_used++;
        blk_start[idx] = heap_top;
        blk_size[idx] = sz;
        blk_free[idx] = 1'b0;
        blk_next[idx] = NONE;
        if (head_blk >= NONE)
            head_blk = idx;
        else if (tail_blk < NONE)
            blk_next[tail_blk] = idx;
        tail_blk = idx;
        heap_top = need;
        st = ST_OK;
        return idx;
    endfunction

    // mark free and absorb free successors, sizes saturate
    function automatic void release_block(input int h);
        int nx;
        int s;
        blk_free[h] = 1'b1;
        for (int n = 0; n < NUM_BLOCKS; n++)
        begin
            nx = blk_next[h];
            if (nx >= NONE || !blk_free[nx])
                break;
            s = blk_size[h] + HDR_BYTES + blk_size[nx];
            blk_size[h] = s > 65535 ? 65535 : s;
            if (nx == tail_blk)
                tail_blk = h;
            blk_next[h] = blk_next[nx];
        end
    endfunction

    function automatic answer_t make_answer(input status_t st, input int h);
        answer_t a;
        a = '0;
        a.status = st;
        if (st == ST_OK && h < NONE)
        begin
            a.handle = h[7:0];
            a.offset = 16'(blk_start[h] + HDR_BYTES);
            a.granted = blk_size[h][15:0];
        end
        return a;
    endfunction

    // expected answer of one request, updating the shadow table
    function automatic answer_t predict_answer(input request_t r);
        status_t st;
        int got;
        int h;
        longint prod;
        bit known;
        h = r.handle;
        known = r.has && h < blocks_used;
        case (r.op)
            OP_ALLOC:
            begin
                got = grant_block(r.size, st);
                return make_answer(st, got);
            end
            OP_FREE:
            begin
                if (!r.has)
                    return make_answer(ST_OK, NONE);
                if (!known || blk_free[h])
                    return make_answer(ST_DOUBLE, NONE);
                release_block(h);
                return make_answer(ST_OK, h);
            end
            OP_REALLOC:
            begin
                if (!r.has || r.size == 0)
                begin
                    got = grant_block(r.size, st);
                    return make_answer(st, got);
                end
                if (!known)
                    return make_answer(ST_DOUBLE, NONE);
                if (blk_size[h] >= r.size)
                    return make_answer(ST_OK, h);
                got = grant_block(r.size, st);
                if (st != ST_OK)
                    return make_answer(st, NONE);
                if (!blk_free[h])
                    release_block(h);
                return make_answer(ST_OK, got);
            end
            default:
            begin
                prod = longint'(r.size) * longint'(r.count);
                if (prod == 0)
                    return make_answer(ST_NULL, NONE);
                if (prod > 65535)
                    return make_answer(ST_OOM, NONE);
                got = grant_block(int'(prod), st);
                return make_answer(st, got);
            end
        endcase
    endfunction

    // driver: presents queued requests, predicts each on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= OP_ALLOC;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
            end
            if ((!s_tvalid || s_tready) && pending_reqs.size() > 0 &&
                ($urandom_range(99) >= send_idle_pct))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, pending_reqs[0].handle, pending_reqs[0].has,
                            pending_reqs[0].count, pending_reqs[0].size};
                s_tuser <= pending_reqs[0].op;
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // monitor: compares each answer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t exp_a;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24]};
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected answer, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_a = expected_answers.pop_front();
                    if (got.status !== exp_a.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_a.status, got.status);
                        errors++;
                    end
                    if (got.handle !== exp_a.handle)
                    begin
                        $display("%0t: handle expected %0d actual %0d", $time,
                                 exp_a.handle, got.handle);
                        errors++;
                    end
                    if (got.offset !== exp_a.offset)
                    begin
                        $display("%0t: offset expected %0d actual %0d", $time,
                                 exp_a.offset, got.offset);
                        errors++;
                    end
                    if (got.granted !== exp_a.granted)
                    begin
                        $display("%0t: granted size expected %0d actual %0d", $time,
                                 exp_a.granted, got.granted);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic request_t mk(input op_t op, input int sz, input int cnt,
                                    input bit has, input int h);
        request_t r;
        r.op = op;
        r.size = sz[15:0];
        r.count = cnt[15:0];
        r.has = has;
        r.handle = h[7:0];
        return r;
    endfunction

    // mostly live handles and small sizes, sometimes extremes and noise
    function automatic request_t random_request();
        int pick;
        int sz;
        int h;
        pick = $urandom_range(99);
        sz = (pick < 85) ? $urandom_range(1, 300) : $urandom_range(0, 65535);
        if ($urandom_range(9) == 0)
            sz = 0;
        h = (blocks_used > 0 && $urandom_range(9) < 8) ?
            $urandom_range(blocks_used + 2) : $urandom_range(255);
        case ($urandom_range(3))
            0: return mk(OP_ALLOC, sz, $urandom, 1'($urandom), $urandom);
            1: return mk(OP_FREE, $urandom, $urandom, $urandom_range(15) != 0, h);
            2: return mk(OP_REALLOC, sz, $urandom, $urandom_range(7) != 0, h);
            default:
                if ($urandom_range(3) == 0)
                    return mk(OP_CALLOC, $urandom, $urandom, 1'($urandom), $urandom);
                else
                    return mk(OP_CALLOC, $urandom_range(0, 40), $urandom_range(0, 12),
                              1'($urandom), $urandom);
        endcase
    endfunction

    // wait for the block to drain, then write the limit
    task automatic write_limit(input int value);
        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (NUM_BLOCKS * 2 + 20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[LIM_W-1:0];
        heap_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // queue a batch, mirroring predictor state only at acceptance
    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            while (pending_reqs.size() > 2)
                @(posedge clk);
            pending_reqs.push_back(random_request());
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        answers_seen = 0;
        send_idle_pct = 30;
        recv_idle_pct = 53;
        heap_limit = LIMIT_RESET;
        head_blk = NONE;
        tail_blk = NONE;
        heap_top = 0;
        blocks_used = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: null, unknown handle, double free, fits, grows, calloc edges
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 0));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 1, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 100, 65535, 1'b1, 255));
        pending_reqs.push_back(mk(OP_ALLOC, 8, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 1));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 2));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 1));
        pending_reqs.push_back(mk(OP_ALLOC, 50, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_REALLOC, 10, 0, 1'b1, 0));
        pending_reqs.push_back(mk(OP_REALLOC, 0, 0, 1'b1, 0));
        pending_reqs.push_back(mk(OP_REALLOC, 20, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_REALLOC, 400, 0, 1'b1, 0));
        pending_reqs.push_back(mk(OP_REALLOC, 5, 0, 1'b1, 200));
        pending_reqs.push_back(mk(OP_REALLOC, 65535, 0, 1'b1, 1));
        pending_reqs.push_back(mk(OP_CALLOC, 0, 5, 1'b0, 0));
        pending_reqs.push_back(mk(OP_CALLOC, 65535, 65535, 1'b0, 0));
        pending_reqs.push_back(mk(OP_CALLOC, 256, 256, 1'b0, 0));
        pending_reqs.push_back(mk(OP_CALLOC, 12, 10, 1'b0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 65535, 0, 1'b0, 0));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 6));
        pending_reqs.push_back(mk(OP_FREE, 0, 0, 1'b1, 5));

        random_phase(150);
        write_limit(0);
        random_phase(20);
        write_limit(131071);
        send_idle_pct = 53;
        recv_idle_pct = 30;
        random_phase(180);
        write_limit(heap_top + 600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(180);
        write_limit(65536);

        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (NUM_BLOCKS * 2 + 20) @(posedge clk);
        $display("covered %0d answers over %0d blocks, heap top %0d, four limit settings",
                 answers_seen, blocks_used, heap_top);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
